[rtl/pis_pkg.sv]
// Package for the particle integrate step block.
// Holds the beat types, codes, color tables and saturation helper; no dependencies.
package pis_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CURRENT_TIME = 1'b0,
    REG_FRAME_TIME   = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    KIND_STATIC   = 3'd0,
    KIND_FIRE     = 3'd1,
    KIND_EXPLODE  = 3'd2,
    KIND_EXPLODE2 = 3'd3,
    KIND_BLOB     = 3'd4,
    KIND_BLOB2    = 3'd5
  } kind_t;

  localparam logic [1:0] STATUS_ALIVE   = 2'd0;
  localparam logic [1:0] STATUS_DROPPED = 2'd1;
  localparam logic [1:0] STATUS_MARKED  = 2'd2;

  // Ramp limits in Q4.12: 6.0 for fire, 8.0 for both explode kinds
  localparam logic [15:0] RAMP_FIRE_LIMIT = 16'd24576;
  localparam logic [15:0] RAMP_EXPL_LIMIT = 16'd32768;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] speed_x;
    logic signed [31:0] speed_y;
    logic signed [31:0] speed_z;
    logic signed [23:0] accel_z;
    logic [15:0]        ramp_pos;
    logic [2:0]         kind;
    logic [31:0]        death_time;
    logic [7:0]         colour_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_speed_x;
    logic signed [31:0] new_speed_y;
    logic signed [31:0] new_speed_z;
    logic [15:0]        new_ramp;
    logic [7:0]         colour_out;
    logic [1:0]         status;
  } out_item_t;

  function automatic logic [7:0] fire_colour(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h6d;
      3'd1:    c = 8'h6b;
      3'd2:    c = 8'h06;
      3'd3:    c = 8'h05;
      3'd4:    c = 8'h04;
      3'd5:    c = 8'h03;
      default: c = 8'h03;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] expl_colour(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h6f;
      3'd1:    c = 8'h6d;
      3'd2:    c = 8'h6b;
      3'd3:    c = 8'h69;
      3'd4:    c = 8'h67;
      3'd5:    c = 8'h65;
      3'd6:    c = 8'h63;
      default: c = 8'h61;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] expl2_colour(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h6f;
      3'd1:    c = 8'h6e;
      3'd2:    c = 8'h6d;
      3'd3:    c = 8'h6c;
      3'd4:    c = 8'h6b;
      3'd5:    c = 8'h6a;
      3'd6:    c = 8'h68;
      default: c = 8'h66;
    endcase
    return c;
  endfunction

  // Clamp a 36-bit signed sum to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if ((v[35:31] == 5'b00000) || (v[35:31] == 5'b11111)) begin
      r = v[31:0];
    end else if (v[35]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

[rtl/pis_if.sv]
// Valid/ready channel interfaces for particle records and results.
// Depends on pis_pkg for the beat payload types.
interface pis_in_if;
  logic               valid;
  logic               ready;
  pis_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pis_out_if;
  logic               valid;
  logic               ready;
  pis_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/pis_ramp_unit.sv]
// Color ramp advance, table lookup and expiry status for one particle.
// Combinational; depends on pis_pkg for kinds, limits and color tables.
module pis_ramp_unit (
  input  logic [2:0]  kind,
  input  logic [15:0] ramp_in,
  input  logic [7:0]  colour_in,
  input  logic [15:0] frame_time,
  input  logic        expired,
  output logic [15:0] ramp_out,
  output logic [7:0]  colour_out,
  output logic [1:0]  status
);
  import pis_pkg::*;

  logic [19:0] inc_full;
  logic [16:0] sum;
  logic [15:0] ramp_sat;
  logic [15:0] limit;
  logic        has_ramp;

  always_comb begin
    has_ramp = 1'b1;
    inc_full = '0;
    limit    = RAMP_EXPL_LIMIT;
    case (kind)
      KIND_FIRE: begin
        inc_full = {2'b00, frame_time, 2'b00} + {4'b0000, frame_time};
        limit    = RAMP_FIRE_LIMIT;
      end
      KIND_EXPLODE: begin
        inc_full = {1'b0, frame_time, 3'b000} + {3'b000, frame_time, 1'b0};
      end
      KIND_EXPLODE2: begin
        inc_full = {frame_time, 4'b0000} - {4'b0000, frame_time};
      end
      default: has_ramp = 1'b0;
    endcase
    sum      = {1'b0, ramp_in} + {1'b0, inc_full[19:4]};
    ramp_sat = sum[16] ? 16'hffff : sum[15:0];
  end

  always_comb begin
    ramp_out   = ramp_in;
    colour_out = colour_in;
    status     = STATUS_ALIVE;
    if (expired) begin
      status = STATUS_DROPPED;
    end else if (has_ramp) begin
      ramp_out = ramp_sat;
      if (ramp_sat >= limit) begin
        status = STATUS_MARKED;
      end else begin
        case (kind)
          KIND_FIRE:    colour_out = fire_colour(ramp_sat[14:12]);
          KIND_EXPLODE: colour_out = expl_colour(ramp_sat[14:12]);
          default:      colour_out = expl2_colour(ramp_sat[14:12]);
        endcase
      end
    end
  end

endmodule

[rtl/particle_integrate_step.sv]
// Top level: four-stage Euler update pipeline for particle records.
// Depends on pis_pkg, pis_if and pis_ramp_unit.
//
//   channel  dir  handshake            payload
//   in_ch    in   valid/ready          pis_pkg::in_item_t  (one particle)
//   out_ch   out  valid/ready          pis_pkg::out_item_t (one result)
//   cfg_*    in   cfg_we, no ready     cfg_index, cfg_data (current/frame time)
//
// One beat per cycle sustained while out_ch is ready; out_ch.valid is the last stage's valid v4_r.
// Stages: expiry, ramp and accel product / z speed sum / three 32x17 and three 32x19
// products / position and velocity sums into the output register.
// Each stage advances when it is empty or the next one advances, so bubbles are
// squeezed out while out_ch is stalled. Synchronous active-low reset clears valids
// and the configuration registers.
module particle_integrate_step (
  input  logic                              clk,
  input  logic                              rst_n,
  pis_in_if.sink                            in_ch,
  pis_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [pis_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pis_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pis_pkg::*;

  typedef enum logic [1:0] {
    VOP_KEEP = 2'd0,
    VOP_ADD  = 2'd1,
    VOP_SUB  = 2'd2
  } vop_t;

  logic [31:0] cur_time_r;
  logic [15:0] frame_time_r;

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  // stage 1
  logic signed [31:0] pos1_r [3];
  logic signed [31:0] spd1_r [3];
  logic signed [40:0] az_prod1_r;
  logic [2:0]         kind1_r;
  logic               exp1_r;
  logic [15:0]        ramp1_r;
  logic [7:0]         col1_r;
  logic [1:0]         st1_r;

  // stage 2
  logic signed [31:0] pos2_r [3];
  logic signed [31:0] spd2_r [3];
  logic [2:0]         kind2_r;
  logic               exp2_r;
  logic [15:0]        ramp2_r;
  logic [7:0]         col2_r;
  logic [1:0]         st2_r;

  // stage 3
  logic signed [31:0] pos3_r [3];
  logic signed [31:0] spd3_r [3];
  logic signed [48:0] pprod3_r [3];
  logic signed [50:0] vprod3_r [3];
  vop_t               vop3_r [3];
  logic               exp3_r;
  logic [15:0]        ramp3_r;
  logic [7:0]         col3_r;
  logic [1:0]         st3_r;

  out_item_t          out4_r;

  logic               expired;
  logic [15:0]        ramp_c;
  logic [7:0]         col_c;
  logic [1:0]         st_c;
  logic signed [40:0] az_prod;
  logic signed [31:0] spd_z2;
  logic signed [18:0] kvel;
  vop_t               vop_c [3];
  logic signed [31:0] pos_n [3];
  logic signed [31:0] spd_n [3];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_time_r   <= '0;
      frame_time_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CURRENT_TIME: cur_time_r   <= cfg_data;
        REG_FRAME_TIME:   frame_time_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign en4 = !v4_r || out_ch.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // stage 1: expiry, ramp/color, accel product
  assign expired = cur_time_r >= in_ch.data.death_time;
  assign az_prod = in_ch.data.accel_z * $signed({1'b0, frame_time_r});

  pis_ramp_unit u_ramp (
    .kind       (in_ch.data.kind),
    .ramp_in    (in_ch.data.ramp_pos),
    .colour_in  (in_ch.data.colour_in),
    .frame_time (frame_time_r),
    .expired    (expired),
    .ramp_out   (ramp_c),
    .colour_out (col_c),
    .status     (st_c)
  );

  always_ff @(posedge clk) begin
    if (en1) begin
      pos1_r[0]  <= in_ch.data.pos_x;
      pos1_r[1]  <= in_ch.data.pos_y;
      pos1_r[2]  <= in_ch.data.pos_z;
      spd1_r[0]  <= in_ch.data.speed_x;
      spd1_r[1]  <= in_ch.data.speed_y;
      spd1_r[2]  <= in_ch.data.speed_z;
      az_prod1_r <= az_prod;
      kind1_r    <= in_ch.data.kind;
      exp1_r     <= expired;
      ramp1_r    <= ramp_c;
      col1_r     <= col_c;
      st1_r      <= st_c;
    end
  end

  // stage 2: z speed gains accel * ft unless the particle has expired
  assign spd_z2 = sat32({{4{spd1_r[2][31]}}, spd1_r[2]}
                        + {{11{az_prod1_r[40]}}, az_prod1_r[40:16]});

  always_ff @(posedge clk) begin
    if (en2) begin
      pos2_r  <= pos1_r;
      spd2_r[0] <= spd1_r[0];
      spd2_r[1] <= spd1_r[1];
      spd2_r[2] <= exp1_r ? spd1_r[2] : spd_z2;
      kind2_r <= kind1_r;
      exp2_r  <= exp1_r;
      ramp2_r <= ramp1_r;
      col2_r  <= col1_r;
      st2_r   <= st1_r;
    end
  end

  // stage 3: position and velocity products
  always_comb begin
    kvel = $signed({1'b0, frame_time_r, 2'b00});
    if (kind2_r == KIND_EXPLODE2) kvel = $signed({3'b000, frame_time_r});
    for (int i = 0; i < 3; i++) begin
      vop_c[i] = VOP_KEEP;
      if (!exp2_r) begin
        case (kind2_r)
          KIND_EXPLODE, KIND_BLOB: vop_c[i] = VOP_ADD;
          KIND_EXPLODE2:           vop_c[i] = VOP_SUB;
          KIND_BLOB2:              vop_c[i] = (i < 2) ? VOP_SUB : VOP_KEEP;
          default:                 vop_c[i] = VOP_KEEP;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int i = 0; i < 3; i++) begin
        pprod3_r[i] <= spd2_r[i] * $signed({1'b0, frame_time_r});
        vprod3_r[i] <= spd2_r[i] * kvel;
        vop3_r[i]   <= vop_c[i];
      end
      pos3_r  <= pos2_r;
      spd3_r  <= spd2_r;
      exp3_r  <= exp2_r;
      ramp3_r <= ramp2_r;
      col3_r  <= col2_r;
      st3_r   <= st2_r;
    end
  end

  // stage 4: saturating sums into the output register
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_n[i] = exp3_r ? pos3_r[i]
               : sat32({{4{pos3_r[i][31]}}, pos3_r[i]}
                       + {{3{pprod3_r[i][48]}}, pprod3_r[i][48:16]});
      case (vop3_r[i])
        VOP_ADD: spd_n[i] = sat32({{4{spd3_r[i][31]}}, spd3_r[i]}
                                  + {vprod3_r[i][50], vprod3_r[i][50:16]});
        VOP_SUB: spd_n[i] = sat32({{4{spd3_r[i][31]}}, spd3_r[i]}
                                  - {vprod3_r[i][50], vprod3_r[i][50:16]});
        default: spd_n[i] = spd3_r[i];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      out4_r.new_pos_x   <= pos_n[0];
      out4_r.new_pos_y   <= pos_n[1];
      out4_r.new_pos_z   <= pos_n[2];
      out4_r.new_speed_x <= spd_n[0];
      out4_r.new_speed_y <= spd_n[1];
      out4_r.new_speed_z <= spd_n[2];
      out4_r.new_ramp    <= ramp3_r;
      out4_r.colour_out  <= col3_r;
      out4_r.status      <= st3_r;
    end
  end

  assign out_ch.valid = v4_r;
  assign out_ch.data  = out4_r;

endmodule

[rtl/pis_checker.sv]
// Port-level checker for particle_integrate_step, attached by bind.
// Depends on pis_pkg for the result beat type and status codes.
module pis_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input pis_pkg::out_item_t  out_data
);
  import pis_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result beat changed while stalled");

  a_marked_ramp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STATUS_MARKED) |-> out_data.new_ramp >= RAMP_FIRE_LIMIT)
    else $error("marked particle below ramp limit");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_acc, 3) && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1)
    && $past(out_ready, 2) && $past(out_ready, 1) && out_ready |=> out_valid)
    else $error("accepted beat missing at output");

endmodule

bind particle_integrate_step pis_checker u_pis_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
